[rtl/core/kdl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kdl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 80;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_REM_KEY   = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } kdl_rec_t;

  // per-cycle commands broadcast along the row
  typedef struct packed {
    logic cap;           // latch key compare
    logic sh_right;      // take record from left neighbour
    logic sh_left;       // take record from right neighbour
    logic sh_left_seen;  // same, only at or behind the first hit
    logic load_tail;     // write new record into the tail slot
  } kdl_ctl_t;

endpackage

`default_nettype wire

[rtl/core/kdl_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module kdl_cell (
  input  wire logic                            clk,
  input  wire kdl_pkg::kdl_ctl_t               ctl,
  input  wire logic signed [kdl_pkg::KEY_W-1:0] cap_key,
  input  wire kdl_pkg::kdl_rec_t               new_rec,
  input  wire kdl_pkg::kdl_rec_t               left_rec,
  input  wire kdl_pkg::kdl_rec_t               right_rec,
  input  wire logic                            occ,
  input  wire logic                            tail,
  input  wire logic                            seen_in,
  output logic                                 seen_out,
  output logic                                 hit,
  output kdl_pkg::kdl_rec_t                    rec
);
  import kdl_pkg::*;

  kdl_rec_t rec_r;
  logic     match_r;

  assign hit      = match_r & occ & ~seen_in;
  assign seen_out = seen_in | (match_r & occ);
  assign rec      = rec_r;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      match_r <= (rec_r.key == cap_key);
    end
    if (ctl.sh_right) begin
      rec_r <= left_rec;
    end else if (ctl.sh_left || (ctl.sh_left_seen && seen_out)) begin
      rec_r <= right_rec;
    end else if (ctl.load_tail && tail) begin
      rec_r <= new_rec;
    end
  end

endmodule

`default_nettype wire

[rtl/core/keyed_deque_list_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// The key compare is latched at item accept; select and shift follow in the execute state, which registers the result.
// No new item is taken until the last one has executed; the per-cell key compare precedes the
// priority chain and the shift of the cell row.
// A waiting result stalls only the execute state; in_tready drops while an item is in work.
// Reset (rst_n low, synchronous) empties the list and clears the output valid.

module keyed_deque_list_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [kdl_pkg::IN_W-1:0]   in_tdata,   // action, key, payload
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [kdl_pkg::OUT_W-1:0]       out_tdata   // status, out_key, out_payload,
                                                      // position, count
);
  import kdl_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r;
  logic [2:0]              act_r;
  logic signed [KEY_W-1:0] key_r;
  logic [PAY_W-1:0]        pay_r;
  logic                    out_valid_r;
  logic [1:0]              status_r;
  logic signed [KEY_W-1:0] okey_r;
  logic [PAY_W-1:0]        opay_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        ocount_r;

  logic in_acc, fire, empty, full, found;
  kdl_ctl_t ctl;
  kdl_rec_t new_rec;
  kdl_rec_t rec [CAPACITY];
  logic [CAPACITY:0]   seen;
  logic [CAPACITY-1:0] hit, occ, tail, last, sel;

  logic [1:0]              status_nxt;
  logic signed [KEY_W-1:0] okey_nxt, sel_key;
  logic [PAY_W-1:0]        opay_nxt, sel_pay;
  logic [POS_W-1:0]        pos_nxt, sel_pos;
  logic [CNT_W-1:0]        count_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign empty     = (count_r == '0);
  assign full      = (count_r >= CNT_W'(CAPACITY));
  assign found     = seen[CAPACITY];

  assign new_rec.key     = key_r;
  assign new_rec.payload = pay_r;

  assign ctl.cap          = in_acc;
  assign ctl.sh_right     = fire && (act_r == ACT_INS_FRONT) && !full;
  assign ctl.load_tail    = fire && (act_r == ACT_INS_BACK) && !full;
  assign ctl.sh_left      = fire && (act_r == ACT_REM_FRONT) && !empty;
  assign ctl.sh_left_seen = fire && (act_r == ACT_REM_KEY);

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kdl_rec_t left_rec, right_rec;

    assign occ[i]  = (CNT_W'(i) < count_r);
    assign tail[i] = (count_r == CNT_W'(i));
    assign last[i] = (count_r == CNT_W'(i + 1));

    if (i == 0) begin : g_head
      assign left_rec = new_rec;
    end else begin : g_mid
      assign left_rec = rec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_rec = rec[i];
    end else begin : g_body
      assign right_rec = rec[i+1];
    end

    kdl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cap_key   (in_tdata[34:3]),
      .new_rec   (new_rec),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .occ       (occ[i]),
      .tail      (tail[i]),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .hit       (hit[i]),
      .rec       (rec[i])
    );
  end

  always_comb begin
    case (act_r)
      ACT_REM_FRONT:           sel = CAPACITY'(1);
      ACT_REM_BACK:            sel = last;
      ACT_SEARCH, ACT_REM_KEY: sel = hit;
      default:                 sel = '0;
    endcase
  end

  // and-or select of the chosen cell
  always_comb begin
    sel_key = '0;
    sel_pay = '0;
    sel_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) begin
        sel_key = sel_key | rec[i].key;
        sel_pay = sel_pay | rec[i].payload;
        sel_pos = sel_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    okey_nxt   = '1;
    opay_nxt   = '0;
    pos_nxt    = '0;
    count_nxt  = count_r;
    case (act_r)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          if (act_r == ACT_INS_BACK) begin
            pos_nxt = POS_W'(count_r);
          end
        end
      end
      ACT_REM_FRONT, ACT_REM_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          okey_nxt  = sel_key;
          opay_nxt  = sel_pay;
          pos_nxt   = sel_pos;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_SEARCH, ACT_REM_KEY: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          okey_nxt = sel_key;
          opay_nxt = sel_pay;
          pos_nxt  = sel_pos;
          if (act_r == ACT_REM_KEY) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (out_tready && !fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r   <= in_tdata[2:0];
            key_r   <= in_tdata[34:3];
            pay_r   <= in_tdata[66:35];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            status_r    <= status_nxt;
            okey_r      <= okey_nxt;
            opay_r      <= opay_nxt;
            pos_r       <= pos_nxt;
            ocount_r    <= count_nxt;
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - 75){1'b0}}, COUNT_W'(ocount_r), pos_r, opay_r, okey_r,
                       status_r};

  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  a_one_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(hit))
    else $error("more than one first match in the row");

  a_fire_out : assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not presented after execute");

  a_search_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (act_r == ACT_SEARCH)) |=> $stable(count_r))
    else $error("search changed the list count");

endmodule

`default_nettype wire

[dv/kdl_checker.sv]
`timescale 1ns / 1ps

module kdl_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [kdl_pkg::IN_W-1:0]  in_tdata,   // action, key, payload
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [kdl_pkg::OUT_W-1:0] out_tdata,  // status, out_key, out_payload, position, count
  output int                        errors,
  output int                        pending,
  output int                        n_full,
  output int                        n_missed
);
  import kdl_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] key;
    logic [31:0] payload;
    logic [3:0]  pos;
    logic [4:0]  cnt;
  } list_result_t;

  logic [31:0]  rec_key [CAPACITY];
  logic [31:0]  rec_pay [CAPACITY];
  int           rec_cnt;
  list_result_t result_q[$];
  list_result_t want, got;

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, seen, wanted);
    errors++;
  endtask

  // close the gap left by the record at idx
  function automatic void drop_record(input int idx);
    for (int i = idx; i + 1 < rec_cnt; i++) begin
      rec_key[i] = rec_key[i+1];
      rec_pay[i] = rec_pay[i+1];
    end
    rec_cnt--;
  endfunction

  function automatic list_result_t apply_list_action(input logic [2:0] act,
                                                     input logic [31:0] key,
                                                     input logic [31:0] pay);
    list_result_t r;
    int idx;
    bit hit;
    r.status  = ST_OK;
    r.key     = '1;
    r.payload = '0;
    r.pos     = '0;
    idx       = 0;
    hit       = 1'b0;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (rec_cnt >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (act == ACT_INS_FRONT) begin
          for (int i = rec_cnt; i > 0; i--) begin
            rec_key[i] = rec_key[i-1];
            rec_pay[i] = rec_pay[i-1];
          end
          rec_key[0] = key;
          rec_pay[0] = pay;
          rec_cnt++;
        end else begin
          rec_key[rec_cnt] = key;
          rec_pay[rec_cnt] = pay;
          r.pos = 4'(rec_cnt);
          rec_cnt++;
        end
      end
      ACT_REM_FRONT, ACT_REM_BACK, ACT_SEARCH, ACT_REM_KEY: begin
        if (rec_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (act == ACT_REM_FRONT) begin
            hit = 1'b1;
          end else if (act == ACT_REM_BACK) begin
            hit = 1'b1;
            idx = rec_cnt - 1;
          end else begin
            // first match from the front wins
            for (int i = 0; i < rec_cnt && !hit; i++) begin
              if (rec_key[i] == key) begin
                hit = 1'b1;
                idx = i;
              end
            end
          end
          if (!hit) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.key     = rec_key[idx];
            r.payload = rec_pay[idx];
            r.pos     = 4'(idx);
            if (act != ACT_SEARCH) drop_record(idx);
          end
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    r.cnt = 5'(rec_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rec_cnt = 0;
      result_q.delete();
      errors   = 0;
      n_full   = 0;
      n_missed = 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        want = apply_list_action(in_tdata[2:0], in_tdata[34:3], in_tdata[66:35]);
        result_q.push_back(want);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_NOTFOUND) n_missed++;
      end
      if (out_tvalid && out_tready) begin
        got.status  = status_t'(out_tdata[1:0]);
        got.key     = out_tdata[33:2];
        got.payload = out_tdata[65:34];
        got.pos     = out_tdata[69:66];
        got.cnt     = out_tdata[74:70];
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", got.key, '1);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.key !== want.key) report_mismatch("key", got.key, want.key);
          if (got.payload !== want.payload)
            report_mismatch("payload", got.payload, want.payload);
          if (got.pos !== want.pos) report_mismatch("position", 32'(got.pos), 32'(want.pos));
          if (got.cnt !== want.cnt) report_mismatch("count", 32'(got.cnt), 32'(want.cnt));
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import kdl_pkg::*;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int         RAND_ITEMS  = 1880;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tready = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [OUT_W-1:0] out_tdata;

  int errors, pending, n_full, n_missed;
  int burst_left, n_ins, n_rem, n_find;
  int rx_mode, rx_left, rx_tick;

  always #6 clk = ~clk;

  keyed_deque_list_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  kdl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending),
    .n_full     (n_full),
    .n_missed   (n_missed)
  );

  // receiver: switches between always ready, coin flip, mostly stalled and a fixed cadence
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_tick % 5 != 0) && (rx_tick % 7 != 3);
    endcase
  end

  task automatic push_item(input logic [2:0] act, input logic [31:0] key,
                           input logic [31:0] pay);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, pay, key, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK:             n_ins++;
      ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_KEY: n_rem++;
      ACT_SEARCH:                               n_find++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // small key pool so that searches and keyed removals hit, with duplicates
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0;
      4, 5, 6, 7, 8: return 32'($urandom_range(1, 6));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int kind, len, roll, ins_pct, rem_pct, n_rand;
    logic [2:0] act;
    bit paused;
    n_rand = 0;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, spare codes, extremes of key and payload, duplicates, misses
    push_item(ACT_REM_FRONT, 32'h0,         32'h0);
    push_item(ACT_REM_BACK,  32'hffff_ffff, 32'hffff_ffff);
    push_item(ACT_SEARCH,    32'h0,         32'h0);
    push_item(ACT_REM_KEY,   32'hffff_ffff, 32'h0);
    push_item(ACT_SPARE_6,   32'h1,         32'h1);
    push_item(ACT_SPARE_7,   32'hffff_ffff, 32'hffff_ffff);
    push_item(ACT_INS_FRONT, 32'h7fff_ffff, 32'hffff_ffff);
    push_item(ACT_INS_BACK,  32'h8000_0000, 32'h0);
    push_item(ACT_INS_FRONT, 32'hffff_ffff, 32'ha5a5_a5a5);
    push_item(ACT_INS_BACK,  32'h0,         32'h5a5a_5a5a);
    push_item(ACT_INS_BACK,  32'h7fff_ffff, 32'h1);
    push_item(ACT_SEARCH,    32'h7fff_ffff, 32'h0);
    push_item(ACT_SEARCH,    32'h0001_2345, 32'h0);
    push_item(ACT_REM_KEY,   32'h0001_2345, 32'h0);
    push_item(ACT_SPARE_6,   32'h7fff_ffff, 32'h0);
    push_item(ACT_REM_KEY,   32'h7fff_ffff, 32'h0);
    push_item(ACT_SEARCH,    32'h7fff_ffff, 32'h0);
    push_item(ACT_REM_BACK,  32'h0,         32'h0);
    push_item(ACT_REM_FRONT, 32'h0,         32'h0);
    push_item(ACT_REM_KEY,   32'h8000_0000, 32'h0);
    push_item(ACT_REM_KEY,   32'h0,         32'h0);
    push_item(ACT_REM_FRONT, 32'h0,         32'h0);

    // phases: grow to full, shrink to empty, search heavy, mixed
    while (n_rand < RAND_ITEMS) begin
      kind = $urandom_range(0, 3);
      len  = $urandom_range(40, 120);
      case (kind)
        0:       begin ins_pct = 75; rem_pct = 10; end
        1:       begin ins_pct = 20; rem_pct = 60; end
        2:       begin ins_pct = 30; rem_pct = 25; end
        default: begin ins_pct = 40; rem_pct = 35; end
      endcase
      for (int k = 0; k < len && n_rand < RAND_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          push_item($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7, $urandom(), $urandom());
          continue;
        end
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
          act = $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_BACK;
        end else if (roll < ins_pct + rem_pct) begin
          case ($urandom_range(0, 2))
            0:       act = ACT_REM_FRONT;
            1:       act = ACT_REM_BACK;
            default: act = ACT_REM_KEY;
          endcase
        end else begin
          act = ACT_SEARCH;
        end
        push_item(act, pick_key(), $urandom());
        n_rand++;
        if (!paused && n_rand == RAND_ITEMS / 2) begin
          // hold off until the block has returned everything
          in_tvalid <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Run covered %0d inserts, %0d removals and %0d searches over grow, shrink,",
             n_ins, n_rem, n_find);
    $display("search and mixed phases; %0d inserts refused as full, %0d keys missed.",
             n_full, n_missed);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d items outstanding", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[keyed_deque_list_top.f]
rtl/core/kdl_pkg.sv
rtl/core/kdl_cell.sv
rtl/core/keyed_deque_list_top.sv
dv/kdl_checker.sv
dv/tb.sv
